// File: sv/ple_pkg.sv
// Types, codes and constants shared by the positional list engine modules.
package ple_pkg;

  localparam int unsigned POS_W = 5;
  localparam int unsigned VAL_W = 32;
  localparam logic [POS_W-1:0] CAP_RESET = 5'd10;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_READ   = 2'd2,
    KIND_FIND   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_POS   = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    kind_t                   kind;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    status_t                 status;
    logic signed [VAL_W-1:0] data_out;
    logic [POS_W-1:0]        found_position;
    logic [POS_W-1:0]        count;
    logic                    is_empty;
    logic                    is_full;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_FETCH,
    ST_READ_OUT,
    ST_DEL_HEAD,
    ST_DEL_RUN,
    ST_UP_FIRST,
    ST_UP_RUN,
    ST_UP_DRAIN,
    ST_PUT,
    ST_SCAN_FIRST,
    ST_SCAN_RUN
  } state_t;

  typedef enum logic [1:0] {
    PTR_TOP,
    PTR_POS,
    PTR_ZERO
  } ptr_sel_t;

  typedef enum logic [1:0] {
    STEP_NONE,
    STEP_INC,
    STEP_DEC
  } step_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_UP,
    WR_DOWN,
    WR_VALUE
  } wr_mode_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  typedef enum logic [1:0] {
    DATA_ZERO,
    DATA_RDATA,
    DATA_KEEP
  } data_sel_t;

  typedef struct packed {
    logic      load;
    logic      ptr_load;
    ptr_sel_t  ptr_sel;
    step_t     ptr_step;
    logic      rd;
    wr_mode_t  wr_mode;
    logic      keep;
    cnt_op_t   cnt_op;
    logic      done;
    status_t   status;
    data_sel_t data_sel;
    logic      found;
  } ctl_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  ins_pos_ok;
    logic  pos_ok;
    logic  full;
    logic  count_zero;
    logic  tail;
    logic  ptr_at_pos;
    logic  src_at_top;
    logic  match;
  } ctl_stat_t;

endpackage

// File: sv/ple_ctrl.sv
// Controller state machine for the positional list engine.
module ple_ctrl
  import ple_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  ctl_stat_t stat,
  output ctl_cmd_t  cmd,
  output logic      busy
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        case (stat.kind)
          KIND_INSERT: begin
            if (!stat.ins_pos_ok || stat.full) begin
              state_nxt = ST_IDLE;
            end else if (stat.tail) begin
              state_nxt = ST_PUT;
            end else begin
              state_nxt = ST_UP_FIRST;
            end
          end
          KIND_DELETE, KIND_READ: begin
            state_nxt = stat.pos_ok ? ST_FETCH : ST_IDLE;
          end
          default: begin
            state_nxt = stat.count_zero ? ST_IDLE : ST_SCAN_FIRST;
          end
        endcase
      end
      ST_FETCH: begin
        state_nxt = (stat.kind == KIND_DELETE) ? ST_DEL_HEAD : ST_READ_OUT;
      end
      ST_READ_OUT: state_nxt = ST_IDLE;
      ST_DEL_HEAD: state_nxt = stat.src_at_top ? ST_IDLE : ST_DEL_RUN;
      ST_DEL_RUN: begin
        if (stat.src_at_top) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_UP_FIRST, ST_UP_RUN: begin
        state_nxt = stat.ptr_at_pos ? ST_UP_DRAIN : ST_UP_RUN;
      end
      ST_UP_DRAIN: state_nxt = ST_PUT;
      ST_PUT: state_nxt = ST_IDLE;
      ST_SCAN_FIRST: state_nxt = ST_SCAN_RUN;
      ST_SCAN_RUN: begin
        if (stat.match || stat.src_at_top) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd          = '0;
    cmd.ptr_sel  = PTR_ZERO;
    cmd.ptr_step = STEP_NONE;
    cmd.wr_mode  = WR_NONE;
    cmd.cnt_op   = CNT_HOLD;
    cmd.status   = STATUS_OK;
    cmd.data_sel = DATA_ZERO;
    case (state_r)
      ST_IDLE: begin
        cmd.load = start;
      end
      ST_CHECK: begin
        case (stat.kind)
          KIND_INSERT: begin
            if (!stat.ins_pos_ok) begin
              cmd.done   = 1'b1;
              cmd.status = STATUS_BAD_POS;
            end else if (stat.full) begin
              cmd.done   = 1'b1;
              cmd.status = STATUS_FULL;
            end else if (!stat.tail) begin
              cmd.ptr_load = 1'b1;
              cmd.ptr_sel  = PTR_TOP;
            end
          end
          KIND_DELETE, KIND_READ: begin
            if (!stat.pos_ok) begin
              cmd.done   = 1'b1;
              cmd.status = STATUS_BAD_POS;
            end else begin
              cmd.ptr_load = 1'b1;
              cmd.ptr_sel  = PTR_POS;
            end
          end
          default: begin
            if (stat.count_zero) begin
              cmd.done   = 1'b1;
              cmd.status = STATUS_NOT_FOUND;
            end else begin
              cmd.ptr_load = 1'b1;
              cmd.ptr_sel  = PTR_ZERO;
            end
          end
        endcase
      end
      ST_FETCH, ST_SCAN_FIRST: begin
        cmd.rd       = 1'b1;
        cmd.ptr_step = STEP_INC;
      end
      ST_READ_OUT: begin
        cmd.done     = 1'b1;
        cmd.data_sel = DATA_RDATA;
      end
      ST_DEL_HEAD: begin
        cmd.keep = 1'b1;
        if (stat.src_at_top) begin
          cmd.done     = 1'b1;
          cmd.data_sel = DATA_RDATA;
          cmd.cnt_op   = CNT_DEC;
        end else begin
          cmd.rd       = 1'b1;
          cmd.ptr_step = STEP_INC;
        end
      end
      ST_DEL_RUN: begin
        cmd.wr_mode = WR_DOWN;
        if (stat.src_at_top) begin
          cmd.done     = 1'b1;
          cmd.data_sel = DATA_KEEP;
          cmd.cnt_op   = CNT_DEC;
        end else begin
          cmd.rd       = 1'b1;
          cmd.ptr_step = STEP_INC;
        end
      end
      ST_UP_FIRST: begin
        cmd.rd       = 1'b1;
        cmd.ptr_step = STEP_DEC;
      end
      ST_UP_RUN: begin
        cmd.rd       = 1'b1;
        cmd.ptr_step = STEP_DEC;
        cmd.wr_mode  = WR_UP;
      end
      ST_UP_DRAIN: begin
        cmd.wr_mode = WR_UP;
      end
      ST_PUT: begin
        cmd.wr_mode = WR_VALUE;
        cmd.cnt_op  = CNT_INC;
        cmd.done    = 1'b1;
      end
      ST_SCAN_RUN: begin
        if (stat.match) begin
          cmd.done  = 1'b1;
          cmd.found = 1'b1;
        end else if (stat.src_at_top) begin
          cmd.done   = 1'b1;
          cmd.status = STATUS_NOT_FOUND;
        end else begin
          cmd.rd       = 1'b1;
          cmd.ptr_step = STEP_INC;
        end
      end
      default: begin
        cmd.done = 1'b0;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  a_load_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == ST_CHECK)
    else $error("accepted item did not enter the check state");

  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.done |=> state_r == ST_IDLE)
    else $error("controller did not return to idle after a result");

  a_ptr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.ptr_load, cmd.ptr_step != STEP_NONE}))
    else $error("pointer loaded and stepped in the same cycle");

endmodule

// File: sv/ple_dpath.sv
// Datapath of the positional list engine: entry memory, count, capacity and result register.
module ple_dpath
  import ple_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  in_item_t         in_item,
  input  logic             cfg_we,
  input  logic [POS_W-1:0] cfg_wdata,
  input  ctl_cmd_t         cmd,
  output ctl_stat_t        stat,
  output logic             out_valid,
  output out_item_t        out_item
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [POS_W-1:0] CAP_MAX = (DEPTH > 31) ? 5'd31 : POS_W'(DEPTH);

  function automatic logic [AW-1:0] to_addr(input logic [POS_W-1:0] x);
    logic [AW+POS_W-1:0] w;
    w = (AW + POS_W)'(x);
    return w[AW-1:0];
  endfunction

  logic [VAL_W-1:0]        entry_store_r [DEPTH];
  in_item_t                req_r;
  logic [POS_W-1:0]        count_r;
  logic [POS_W-1:0]        count_nxt;
  logic [POS_W-1:0]        cap_r;
  logic [AW-1:0]           ptr_r;
  logic [AW-1:0]           ptr_nxt;
  logic [AW-1:0]           src_r;
  logic signed [VAL_W-1:0] rdata_r;
  logic signed [VAL_W-1:0] keep_r;
  logic                    out_valid_r;
  out_item_t               out_item_r;
  out_item_t               out_item_nxt;

  logic [POS_W-1:0]        pos_m1;
  logic [POS_W-1:0]        cnt_m1;
  logic [AW-1:0]           pos_addr;
  logic [AW-1:0]           top_addr;
  logic [POS_W:0]          cnt_p1;
  logic [AW-1:0]           wr_addr;
  logic [VAL_W-1:0]        wr_data;
  logic [AW+POS_W:0]       src_p1;

  assign pos_m1   = req_r.position - 5'd1;
  assign cnt_m1   = count_r - 5'd1;
  assign pos_addr = to_addr(pos_m1);
  assign top_addr = to_addr(cnt_m1);
  assign cnt_p1   = {1'b0, count_r} + 6'd1;
  assign src_p1   = (AW + POS_W + 1)'(src_r) + 1'b1;

  // Status toward the controller.
  always_comb begin
    stat.kind       = req_r.kind;
    stat.ins_pos_ok = (req_r.position != '0) && ({1'b0, req_r.position} <= cnt_p1);
    stat.pos_ok     = (req_r.position != '0) && (req_r.position <= count_r);
    stat.full       = (count_r >= cap_r) || (32'(count_r) >= DEPTH);
    stat.count_zero = (count_r == '0);
    stat.tail       = ({1'b0, req_r.position} == cnt_p1);
    stat.ptr_at_pos = (ptr_r == pos_addr);
    stat.src_at_top = (src_r == top_addr);
    stat.match      = (rdata_r == req_r.value);
  end

  // Walk pointer: load a start address, then step one entry a cycle.
  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.ptr_load) begin
      case (cmd.ptr_sel)
        PTR_TOP: ptr_nxt = top_addr;
        PTR_POS: ptr_nxt = pos_addr;
        default: ptr_nxt = '0;
      endcase
    end else begin
      case (cmd.ptr_step)
        STEP_INC: ptr_nxt = ptr_r + AW'(1);
        STEP_DEC: ptr_nxt = ptr_r - AW'(1);
        default:  ptr_nxt = ptr_r;
      endcase
    end
  end

  // Write port: move the last fetched entry up or down, or drop in the new value.
  always_comb begin
    case (cmd.wr_mode)
      WR_UP:    wr_addr = src_r + AW'(1);
      WR_DOWN:  wr_addr = src_r - AW'(1);
      default:  wr_addr = pos_addr;
    endcase
    wr_data = (cmd.wr_mode == WR_VALUE) ? req_r.value : rdata_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_mode != WR_NONE) begin
      entry_store_r[wr_addr] <= wr_data;
    end
    if (cmd.rd) begin
      rdata_r <= entry_store_r[ptr_r];
    end
  end

  always_comb begin
    case (cmd.cnt_op)
      CNT_INC: count_nxt = count_r + 5'd1;
      CNT_DEC: count_nxt = count_r - 5'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_comb begin
    out_item_nxt.status = cmd.status;
    case (cmd.data_sel)
      DATA_RDATA: out_item_nxt.data_out = rdata_r;
      DATA_KEEP:  out_item_nxt.data_out = keep_r;
      default:    out_item_nxt.data_out = '0;
    endcase
    out_item_nxt.found_position = cmd.found ? src_p1[POS_W-1:0] : '0;
    out_item_nxt.count          = count_nxt;
    out_item_nxt.is_empty       = (count_nxt == '0);
    out_item_nxt.is_full        = (count_nxt >= cap_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= cmd.done;
      if (cfg_we) begin
        cap_r <= (32'(cfg_wdata) > DEPTH) ? CAP_MAX : cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (cmd.load) begin
      req_r <= in_item;
    end
    if (cmd.rd) begin
      src_r <= ptr_r;
    end
    if (cmd.keep) begin
      keep_r <= rdata_r;
    end
    if (cmd.done) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= DEPTH)
    else $error("entry count exceeds store depth");

  a_count_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(count_r) |-> out_valid_r)
    else $error("entry count changed without a result");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for more than one cycle");

endmodule

// File: sv/positional_list_engine_unit.sv
// Top level of the positional list engine: controller plus datapath.
//
// The unit keeps an ordered list of signed 32-bit values in a simple
// dual-port memory of DEPTH entries, with a count. An item is taken when start is
// high and busy is low; exactly one result follows on out_item, marked by a
// one-cycle out_valid pulse, and the receiver cannot stall it. Entries move
// one per cycle through the memory (one read and one write a cycle). busy
// drops in the cycle of the result pulse, so the next item can be taken then.
// Writing cfg_wdata with cfg_we sets the capacity, saturated at DEPTH; write
// it only while busy is low. Reset is synchronous and needs no clearing pass.
module positional_list_engine_unit
  import ple_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_item_t         in_item,
  output logic             out_valid,
  output out_item_t        out_item,
  input  logic             cfg_we,
  input  logic [POS_W-1:0] cfg_wdata
);

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  // Sequence each request: check, walk the memory, post the result.
  ple_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Hold the list, count and capacity; drive the result register.
  ple_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// File: tb/sv/list_check_pkg.sv
// Shadow copy of the positional list and the queue of replies it predicts.
package list_check_pkg;
  import ple_pkg::*;

  localparam int LIST_DEPTH = 16;

  class list_mirror;
    logic signed [VAL_W-1:0] slots [LIST_DEPTH];
    int                      used;
    int                      cap;
    out_item_t               predicted_replies [$];
    int unsigned             mismatches;

    function new();
      used       = 0;
      cap        = CAP_RESET;
      mismatches = 0;
    endfunction

    // Saturate at the store depth, as the block does.
    function void write_capacity(logic [POS_W-1:0] wdata);
      cap = (wdata > LIST_DEPTH) ? LIST_DEPTH : wdata;
    endfunction

    function int list_length();
      return used;
    endfunction

    function logic signed [VAL_W-1:0] entry_at(int idx);
      return slots[idx];
    endfunction

    function int outstanding();
      return predicted_replies.size();
    endfunction

    // Apply one accepted request to the shadow list and queue its reply.
    function void note_request(in_item_t req);
      out_item_t rsp;
      int        p;
      int        j;
      p          = req.position;
      rsp        = '0;
      rsp.status = STATUS_OK;
      case (req.kind)
        KIND_INSERT: begin
          if (p < 1 || p > used + 1) begin
            rsp.status = STATUS_BAD_POS;
          end else if (used >= cap || used >= LIST_DEPTH) begin
            rsp.status = STATUS_FULL;
          end else begin
            for (j = used; j >= p; j--) slots[j] = slots[j-1];
            slots[p-1] = req.value;
            used++;
          end
        end
        KIND_DELETE: begin
          if (p < 1 || p > used) begin
            rsp.status = STATUS_BAD_POS;
          end else begin
            rsp.data_out = slots[p-1];
            for (j = p; j < used; j++) slots[j-1] = slots[j];
            used--;
          end
        end
        KIND_READ: begin
          if (p < 1 || p > used) rsp.status = STATUS_BAD_POS;
          else rsp.data_out = slots[p-1];
        end
        KIND_FIND: begin
          rsp.status = STATUS_NOT_FOUND;
          for (j = 0; j < used; j++) begin
            if (slots[j] == req.value) begin
              rsp.found_position = POS_W'(j + 1);
              rsp.status         = STATUS_OK;
              break;
            end
          end
        end
      endcase
      rsp.count    = used[POS_W-1:0];
      rsp.is_empty = (used == 0);
      rsp.is_full  = (used >= cap);
      predicted_replies.push_back(rsp);
    endfunction

    function void compare_field(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0h, got %0h", name, want, got);
        mismatches++;
      end
    endfunction

    // Match one reply from the block against the oldest prediction.
    function void check_reply(out_item_t got);
      out_item_t want;
      if (predicted_replies.size() == 0) begin
        $error("reply with no request outstanding: %h", got);
        mismatches++;
        return;
      end
      want = predicted_replies.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("data_out", want.data_out, got.data_out);
      compare_field("found_position", want.found_position, got.found_position);
      compare_field("count", want.count, got.count);
      compare_field("is_empty", want.is_empty, got.is_empty);
      compare_field("is_full", want.is_full, got.is_full);
    endfunction
  endclass

endpackage

// File: tb/sv/tb_top.sv
// Testbench top: drives list requests and capacity writes, checks every reply.
module tb_top;
  import ple_pkg::*;
  import list_check_pkg::*;

  localparam int WATCHDOG_LIMIT  = 400;  // cycles with no item moving either way
  localparam int SETTLE_CYCLES   = 24;   // longest insert latency plus margin
  localparam int ITEMS_PER_PHASE = 95;
  localparam int NUM_PHASES      = 9;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  in_item_t         in_item;
  logic             out_valid;
  out_item_t        out_item;
  logic             cfg_we;
  logic [POS_W-1:0] cfg_wdata;

  list_mirror mirror = new();
  int         idle_pct;
  int         stall_cycles;

  // Per-phase capacity, operation mix and sender idling. Capacity walks the
  // extremes: full depth, above depth (saturates), zero, one, and values that
  // land below the count left by the previous phase. The last phase never idles.
  int phase_cap  [NUM_PHASES] = '{16, 31, 3, 0, 1, 16, 7, 17, 10};
  int phase_ins  [NUM_PHASES] = '{ 6,  3, 2, 2, 3,  5, 3,  4,  3};
  int phase_del  [NUM_PHASES] = '{ 2,  3, 4, 3, 3,  2, 3,  2,  3};
  int phase_idle [NUM_PHASES] = '{30,  0, 50, 30, 20, 40, 0, 30, 0};

  positional_list_engine_unit #(.DEPTH(LIST_DEPTH)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Check each reply pulse at the edge that ends it; the receiver cannot stall.
  always @(posedge clk) begin
    if (rst_n && out_valid) mirror.check_reply(out_item);
  end

  // Count edges at which no item moves in either direction; bail out at the limit.
  initial begin
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (start && !busy) || out_valid) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("positional_list_engine_unit test failed");
    $finish;
  end

  // Present one request at the falling edge, hold it until the block takes it,
  // then maybe drop start for a short random burst.
  task automatic issue(input kind_t k, input logic [POS_W-1:0] p,
                       input logic signed [VAL_W-1:0] v);
    in_item_t req;
    req.kind     = k;
    req.position = p;
    req.value    = v;
    @(negedge clk);
    start   <= 1'b1;
    in_item <= req;
    do @(posedge clk); while (busy);
    mirror.note_request(req);
    if ($urandom_range(0, 99) < idle_pct) begin
      repeat ($urandom_range(1, 3)) begin
        @(negedge clk);
        start <= 1'b0;
      end
    end
  endtask

  // Drop start, wait until every predicted reply has come back, then pause.
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (mirror.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the capacity register; call only while the block is idle.
  task automatic set_capacity(input logic [POS_W-1:0] cap);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(negedge clk);
    cfg_we    <= 1'b0;
    mirror.write_capacity(cap);
  endtask

  // Mostly full-range values, with small ones for duplicates and the extremes.
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      5, 6, 7: return $urandom_range(0, 7);
      8:       return ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
      9:       return ($urandom_range(0, 1) != 0) ? -32'sd1 : 32'sd0;
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed requests against the current list; some raw noise.
  task automatic random_item(input int ins_w, del_w, rd_w, fd_w);
    int                      roll;
    int                      n;
    kind_t                   k;
    logic [POS_W-1:0]        p;
    logic signed [VAL_W-1:0] v;
    n    = mirror.list_length();
    roll = $urandom_range(0, ins_w + del_w + rd_w + fd_w - 1);
    if (roll < ins_w) k = KIND_INSERT;
    else if (roll < ins_w + del_w) k = KIND_DELETE;
    else if (roll < ins_w + del_w + rd_w) k = KIND_READ;
    else k = KIND_FIND;
    v = pick_value();
    if ($urandom_range(0, 99) < 12) p = POS_W'($urandom_range(0, 31));
    else if (k == KIND_INSERT) p = POS_W'($urandom_range(1, n + 1));
    else p = (n == 0) ? POS_W'(1) : POS_W'($urandom_range(1, n));
    // Search mostly for values that are really there.
    if (k == KIND_FIND && n > 0 && $urandom_range(0, 9) < 6) v = mirror.entry_at($urandom_range(0, n - 1));
    issue(k, p, v);
  endtask

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    idle_pct  = 25;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty list: reads, deletes and finds have nothing to hit.
    issue(KIND_READ, 1, 0);
    issue(KIND_DELETE, 0, 0);
    issue(KIND_FIND, 0, 0);
    // Insert positions outside 1..count+1 are rejected.
    issue(KIND_INSERT, 0, 5);
    issue(KIND_INSERT, 2, 5);
    // Build [min, 0, max, -1] via head, head, tail and middle inserts.
    issue(KIND_INSERT, 1, 32'sh7fffffff);
    issue(KIND_INSERT, 1, 32'sh80000000);
    issue(KIND_INSERT, 3, -32'sd1);
    issue(KIND_INSERT, 2, 32'sd0);
    for (int i = 1; i <= 4; i++) issue(KIND_READ, POS_W'(i), 0);
    // Read just past the count and at the top of the position range.
    issue(KIND_READ, 5, 0);
    issue(KIND_READ, 31, 0);
    issue(KIND_FIND, 0, -32'sd1);
    issue(KIND_FIND, 31, 32'sh80000000);
    issue(KIND_FIND, 0, 32'sd12345);
    // Remove the tail, then the head, then try a position far out of range.
    issue(KIND_DELETE, 4, 0);
    issue(KIND_DELETE, 1, 0);
    issue(KIND_DELETE, 31, 0);

    // Capacity lowered below the count: entries stay, inserts report full,
    // but a bad position still wins over full.
    settle();
    set_capacity(1);
    issue(KIND_INSERT, 1, 32'sd77);
    issue(KIND_INSERT, 9, 32'sd77);
    issue(KIND_FIND, 0, 32'sd0);
    // Capacity zero: every insert reports full.
    settle();
    set_capacity(0);
    issue(KIND_INSERT, 3, 32'sd77);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      set_capacity(POS_W'(phase_cap[ph]));
      idle_pct = phase_idle[ph];
      repeat (ITEMS_PER_PHASE) random_item(phase_ins[ph], phase_del[ph], 2, 2);
    end
    settle();

    if (mirror.mismatches == 0 && mirror.outstanding() == 0) begin
      $display("positional_list_engine_unit test passed");
    end else begin
      $display("positional_list_engine_unit test failed");
    end
    $finish;
  end

endmodule
